// File: rtl/h2r_pkg.sv
// ----------------------------------------------------------------------------
// h2r_pkg
// Shared types and constants of the HSV to RGB converter pipeline.
// ----------------------------------------------------------------------------
package h2r_pkg;

  localparam int HUE_W = 15;
  localparam int CH_W  = 8;
  localparam int LVL_W = 16;   // channel level with 8 fraction bits

  // Division by 15 as multiply by reciprocal: floor(y / 15) equals
  // (y * DIV15_MUL) >> DIV15_SH for every y below 2^20.
  localparam int             DIV15_SH    = 24;
  localparam int             DIV15_MUL_W = 21;
  localparam int             DIV15_IN_W  = 20;
  localparam logic [DIV15_MUL_W-1:0] DIV15_MUL = 21'd1118482;

  // Hue sectors of 60 degrees, named after the colors they run between.
  typedef enum logic [2:0] {
    SEC_RY = 3'd0,
    SEC_YG = 3'd1,
    SEC_GC = 3'd2,
    SEC_CB = 3'd3,
    SEC_BM = 3'd4,
    SEC_MR = 3'd5
  } h2r_sector_t;

  // Levels of one pixel once top and bottom are known.
  typedef struct packed {
    h2r_sector_t        sector;
    logic [CH_W-1:0]    top;
    logic [LVL_W-1:0]   bottom;
    logic [LVL_W-1:0]   span;
  } h2r_lvl_t;

  // Levels of one pixel once the ramp is known.
  typedef struct packed {
    h2r_sector_t        sector;
    logic [CH_W-1:0]    top;
    logic [LVL_W-1:0]   bottom;
    logic [LVL_W-1:0]   ramp;
  } h2r_mix_t;

endpackage

// File: rtl/hsv_to_rgb_converter_core.sv
// ----------------------------------------------------------------------------
// hsv_to_rgb_converter_core
// Streaming HSV to 8-bit RGB pixel converter, five pipeline stages.
// ----------------------------------------------------------------------------
// The converter takes one pixel request per clock while the output side is
// not stalled and returns one RGB result per request, in order, so throughput
// is then one pixel every cycle. The five register stages are hue sector
// search and saturation product, bottom level and span, span times phase, the
// reciprocal multiply that divides by the sector width, and the channel choice
// in the output register. Each stage carries its own valid bit and moves
// whenever the stage after it is empty or moving, so bubbles close up and
// in_tready stays high whenever any stage is free. A stall on out_tready holds
// every full stage with no bubble after it; nothing is dropped or duplicated.
// Hue is degrees times 2^HUE_FRAC_BITS and is saturated just below 360
// degrees; saturation and brightness run from 0 to 255. All levels keep 8
// fraction bits internally and each channel is truncated at the end. The
// block keeps no state between pixels and has no configuration.
// ----------------------------------------------------------------------------
module hsv_to_rgb_converter_core #(
  parameter int HUE_FRAC_BITS = 6
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,    // hue [14:0], saturation [22:15], brightness [30:23]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata    // red [7:0], green [15:8], blue [23:16]
);
  import h2r_pkg::*;

  localparam int PH_W = HUE_FRAC_BITS + 6;

  // Request fields as packed on the input bus.
  logic [HUE_W-1:0] hue;
  logic [CH_W-1:0]  saturation, brightness;

  // Handshakes between the three sections of the pipeline.
  logic             prep_valid, prep_ready, ramp_valid, ramp_ready;
  h2r_lvl_t         prep_lvl;
  logic [PH_W-1:0]  prep_phase;
  h2r_mix_t         ramp_mix;
  logic [CH_W-1:0]  red, green, blue;

  assign hue        = in_tdata[14:0];
  assign saturation = in_tdata[22:15];
  assign brightness = in_tdata[30:23];

  // Stages one and two: sector, phase, bottom level and span.
  h2r_prep #(
    .HUE_FRAC_BITS (HUE_FRAC_BITS)
  ) u_prep (
    .clk        (clk),
    .rst_n      (rst_n),
    .s_valid    (in_tvalid),
    .s_ready    (in_tready),
    .hue        (hue),
    .saturation (saturation),
    .brightness (brightness),
    .m_valid    (prep_valid),
    .m_ready    (prep_ready),
    .m_lvl      (prep_lvl),
    .m_phase    (prep_phase)
  );

  // Stages three and four: the ramp, span * phase / sector width.
  h2r_ramp #(
    .HUE_FRAC_BITS (HUE_FRAC_BITS)
  ) u_ramp (
    .clk     (clk),
    .rst_n   (rst_n),
    .s_valid (prep_valid),
    .s_ready (prep_ready),
    .s_lvl   (prep_lvl),
    .s_phase (prep_phase),
    .m_valid (ramp_valid),
    .m_ready (ramp_ready),
    .m_mix   (ramp_mix)
  );

  // Stage five: the sector picks top, bottom, rising or falling per channel.
  h2r_mix u_mix (
    .clk     (clk),
    .rst_n   (rst_n),
    .s_valid (ramp_valid),
    .s_ready (ramp_ready),
    .s_mix   (ramp_mix),
    .m_valid (out_tvalid),
    .m_ready (out_tready),
    .red     (red),
    .green   (green),
    .blue    (blue)
  );

  assign out_tdata = {blue, green, red};

endmodule

// File: rtl/h2r_prep.sv
// ----------------------------------------------------------------------------
// h2r_prep
// Two pipeline stages: hue sector and phase, then bottom level and span.
// ----------------------------------------------------------------------------
module h2r_prep #(
  parameter int HUE_FRAC_BITS = 6
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         s_valid,
  output logic                         s_ready,
  input  logic [h2r_pkg::HUE_W-1:0]    hue,
  input  logic [h2r_pkg::CH_W-1:0]     saturation,
  input  logic [h2r_pkg::CH_W-1:0]     brightness,
  output logic                         m_valid,
  input  logic                         m_ready,
  output h2r_pkg::h2r_lvl_t            m_lvl,
  output logic [HUE_FRAC_BITS+5:0]     m_phase
);
  import h2r_pkg::*;

  localparam int PH_W  = HUE_FRAC_BITS + 6;
  localparam int CMP_W = (HUE_W > HUE_FRAC_BITS + 9) ? HUE_W : HUE_FRAC_BITS + 9;
  localparam int SECT  = 60 * (1 << HUE_FRAC_BITS);
  localparam logic [CMP_W-1:0] LIMIT = CMP_W'(6 * SECT - 1);
  localparam logic [CMP_W-1:0] B1    = CMP_W'(SECT);
  localparam logic [CMP_W-1:0] B2    = CMP_W'(2 * SECT);
  localparam logic [CMP_W-1:0] B3    = CMP_W'(3 * SECT);
  localparam logic [CMP_W-1:0] B4    = CMP_W'(4 * SECT);
  localparam logic [CMP_W-1:0] B5    = CMP_W'(5 * SECT);

  logic                va_r, vb_r, adv_a, adv_b;
  logic [CMP_W-1:0]    hue_x, hue_c, base;
  h2r_sector_t         sec_nxt, sec_a_r;
  logic [PH_W-1:0]     ph_nxt, ph_a_r, ph_b_r;
  logic [CH_W-1:0]     top_a_r;
  logic [LVL_W-1:0]    prod_nxt, prod_a_r, tmp, bottom_nxt;
  h2r_lvl_t            lvl_nxt, lvl_b_r;

  assign adv_b   = !vb_r || m_ready;
  assign adv_a   = !va_r || adv_b;
  assign s_ready = adv_a;

  // Hue saturates just below 360 degrees, then the sector is found by compare.
  always_comb begin
    hue_x = CMP_W'(hue);
    hue_c = (hue_x > LIMIT) ? LIMIT : hue_x;
    if (hue_c >= B5) begin
      sec_nxt = SEC_MR;
      base    = B5;
    end else if (hue_c >= B4) begin
      sec_nxt = SEC_BM;
      base    = B4;
    end else if (hue_c >= B3) begin
      sec_nxt = SEC_CB;
      base    = B3;
    end else if (hue_c >= B2) begin
      sec_nxt = SEC_GC;
      base    = B2;
    end else if (hue_c >= B1) begin
      sec_nxt = SEC_YG;
      base    = B1;
    end else begin
      sec_nxt = SEC_RY;
      base    = '0;
    end
    ph_nxt   = PH_W'(hue_c - base);
    prod_nxt = {8'd0, brightness} * {8'd0, ~saturation};
  end

  // bottom = floor(256 * p / 255) = p + floor(p / 255); the quotient by 255
  // is exact for p up to 255 * 255.
  always_comb begin
    tmp            = prod_a_r + 16'd1 + {8'd0, prod_a_r[15:8]};
    bottom_nxt     = prod_a_r + {8'd0, tmp[15:8]};
    lvl_nxt.sector = sec_a_r;
    lvl_nxt.top    = top_a_r;
    lvl_nxt.bottom = bottom_nxt;
    lvl_nxt.span   = {top_a_r, 8'd0} - bottom_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
      vb_r <= 1'b0;
    end else begin
      if (adv_a) va_r <= s_valid;
      if (adv_b) vb_r <= va_r;
    end
    if (adv_a && s_valid) begin
      sec_a_r  <= sec_nxt;
      ph_a_r   <= ph_nxt;
      top_a_r  <= brightness;
      prod_a_r <= prod_nxt;
    end
    if (adv_b && va_r) begin
      lvl_b_r <= lvl_nxt;
      ph_b_r  <= ph_a_r;
    end
  end

  assign m_valid = vb_r;
  assign m_lvl   = lvl_b_r;
  assign m_phase = ph_b_r;

endmodule

// File: rtl/h2r_ramp.sv
// ----------------------------------------------------------------------------
// h2r_ramp
// Two pipeline stages: span times phase, then division by the sector width.
// ----------------------------------------------------------------------------
module h2r_ramp #(
  parameter int HUE_FRAC_BITS = 6
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         s_valid,
  output logic                         s_ready,
  input  h2r_pkg::h2r_lvl_t            s_lvl,
  input  logic [HUE_FRAC_BITS+5:0]     s_phase,
  output logic                         m_valid,
  input  logic                         m_ready,
  output h2r_pkg::h2r_mix_t            m_mix
);
  import h2r_pkg::*;

  localparam int PH_W   = HUE_FRAC_BITS + 6;
  localparam int PROD_W = LVL_W + PH_W;
  localparam int SHIFT  = HUE_FRAC_BITS + 2;      // sector width is 15 << SHIFT
  localparam int Q_W    = DIV15_IN_W + DIV15_MUL_W;

  logic                  vc_r, vd_r, adv_c, adv_d;
  logic [PROD_W-1:0]     prod_c_r;
  h2r_lvl_t              lvl_c_r;
  logic [DIV15_IN_W-1:0] y;
  logic [Q_W-1:0]        q;
  h2r_mix_t              mix_nxt, mix_d_r;

  assign adv_d   = !vd_r || m_ready;
  assign adv_c   = !vc_r || adv_d;
  assign s_ready = adv_c;

  always_comb begin
    y              = prod_c_r[PROD_W-1:SHIFT];
    q              = {{DIV15_MUL_W{1'b0}}, y} * {{DIV15_IN_W{1'b0}}, DIV15_MUL};
    mix_nxt.sector = lvl_c_r.sector;
    mix_nxt.top    = lvl_c_r.top;
    mix_nxt.bottom = lvl_c_r.bottom;
    mix_nxt.ramp   = q[DIV15_SH +: LVL_W];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vc_r <= 1'b0;
      vd_r <= 1'b0;
    end else begin
      if (adv_c) vc_r <= s_valid;
      if (adv_d) vd_r <= vc_r;
    end
    if (adv_c && s_valid) begin
      prod_c_r <= {{PH_W{1'b0}}, s_lvl.span} * {{LVL_W{1'b0}}, s_phase};
      lvl_c_r  <= s_lvl;
    end
    if (adv_d && vc_r) begin
      mix_d_r <= mix_nxt;
    end
  end

  assign m_valid = vd_r;
  assign m_mix   = mix_d_r;

endmodule

// File: rtl/h2r_mix.sv
// ----------------------------------------------------------------------------
// h2r_mix
// Last stage: rising and falling levels, channel choice, output register.
// ----------------------------------------------------------------------------
module h2r_mix (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      s_valid,
  output logic                      s_ready,
  input  h2r_pkg::h2r_mix_t         s_mix,
  output logic                      m_valid,
  input  logic                      m_ready,
  output logic [h2r_pkg::CH_W-1:0]  red,
  output logic [h2r_pkg::CH_W-1:0]  green,
  output logic [h2r_pkg::CH_W-1:0]  blue
);
  import h2r_pkg::*;

  logic             ve_r, adv_e;
  logic [LVL_W-1:0] top_q, rise, fall, r_lv, g_lv, b_lv;
  logic [CH_W-1:0]  red_r, green_r, blue_r;

  assign adv_e   = !ve_r || m_ready;
  assign s_ready = adv_e;

  always_comb begin
    top_q = {s_mix.top, 8'd0};
    rise  = s_mix.bottom + s_mix.ramp;
    fall  = top_q - s_mix.ramp;
    case (s_mix.sector)
      SEC_RY: begin
        r_lv = top_q;        g_lv = rise;         b_lv = s_mix.bottom;
      end
      SEC_YG: begin
        r_lv = fall;         g_lv = top_q;        b_lv = s_mix.bottom;
      end
      SEC_GC: begin
        r_lv = s_mix.bottom; g_lv = top_q;        b_lv = rise;
      end
      SEC_CB: begin
        r_lv = s_mix.bottom; g_lv = fall;         b_lv = top_q;
      end
      SEC_BM: begin
        r_lv = rise;         g_lv = s_mix.bottom; b_lv = top_q;
      end
      default: begin
        r_lv = top_q;        g_lv = s_mix.bottom; b_lv = fall;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ve_r <= 1'b0;
    end else if (adv_e) begin
      ve_r <= s_valid;
    end
    if (adv_e && s_valid) begin
      red_r   <= r_lv[LVL_W-1:8];
      green_r <= g_lv[LVL_W-1:8];
      blue_r  <= b_lv[LVL_W-1:8];
    end
  end

  assign m_valid = ve_r;
  assign red     = red_r;
  assign green   = green_r;
  assign blue    = blue_r;

endmodule

// File: rtl/h2r_checker.sv
// ----------------------------------------------------------------------------
// h2r_checker
// Port-level assertions for the HSV to RGB converter, bound to the top level.
// ----------------------------------------------------------------------------
module h2r_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [23:0] out_tdata
);

  // Reset empties the pipeline, so no result shows in the cycle after it.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid right after reset");

  // A stalled result stays offered.
  a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("result withdrawn while stalled");

  // A stalled result keeps its value.
  a_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> $stable(out_tdata))
    else $error("result changed while stalled");

  // When the output stage is empty or draining, the whole pipeline can move,
  // so the converter must take a new pixel.
  a_ready_free: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid || out_tready |-> in_tready)
    else $error("input blocked although the pipeline can move");

endmodule

bind hsv_to_rgb_converter_core h2r_checker u_h2r_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

// File: dv/hsv_to_rgb_converter_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// hsv_to_rgb_converter_checker
// Watches both streams of the converter, predicts each pixel and compares.
// ----------------------------------------------------------------------------
module hsv_to_rgb_converter_checker #(
  parameter int HUE_FRAC_BITS = 6
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [31:0] in_tdata,    // hue [14:0], saturation [22:15], brightness [30:23]
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [23:0] out_tdata,   // red [7:0], green [15:8], blue [23:16]
  output int          mismatch_count,
  output int          pending_count
);
  import h2r_pkg::*;

  typedef struct packed {
    logic [CH_W-1:0] blue;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] red;
  } rgb_t;

  localparam longint unsigned SECTOR_WIDTH = 64'd60 << HUE_FRAC_BITS;
  localparam longint unsigned HUE_CEILING  = (64'd360 << HUE_FRAC_BITS) - 1;

  rgb_t rgb_expected_q[$];
  int   errors  = 0;
  int   waiting = 0;

  assign mismatch_count = errors;
  assign pending_count  = waiting;

  // Computes one pixel with 8 fraction bits on every level.
  function automatic rgb_t hsv_to_rgb(input logic [HUE_W-1:0] hue_in,
                                      input logic [CH_W-1:0] sat,
                                      input logic [CH_W-1:0] val);
    logic [63:0] hue, top, bottom, span, phase, ramp, rise, fall;
    logic [63:0] r, g, b;
    h2r_sector_t sector;
    rgb_t        px;
    hue = 64'(hue_in);
    if (hue > HUE_CEILING) begin
      hue = HUE_CEILING;
    end
    top    = 64'(val) << 8;
    bottom = (64'(val) * (64'd255 - 64'(sat)) * 64'd256) / 64'd255;
    span   = top - bottom;
    sector = h2r_sector_t'(hue / SECTOR_WIDTH);
    phase  = hue % SECTOR_WIDTH;
    ramp   = (span * phase) / SECTOR_WIDTH;
    rise   = bottom + ramp;
    fall   = top - ramp;
    case (sector)
      SEC_RY: begin r = top;    g = rise;   b = bottom; end
      SEC_YG: begin r = fall;   g = top;    b = bottom; end
      SEC_GC: begin r = bottom; g = top;    b = rise;   end
      SEC_CB: begin r = bottom; g = fall;   b = top;    end
      SEC_BM: begin r = rise;   g = bottom; b = top;    end
      default: begin r = top;   g = bottom; b = fall;   end
    endcase
    px.red   = r[15:8];
    px.green = g[15:8];
    px.blue  = b[15:8];
    return px;
  endfunction

  always @(posedge clk) begin : watch
    rgb_t want;
    rgb_t got;
    if (rst_n) begin
      if (in_tvalid && in_tready) begin
        rgb_expected_q.push_back(hsv_to_rgb(in_tdata[14:0], in_tdata[22:15],
                                            in_tdata[30:23]));
      end
      if (out_tvalid && out_tready) begin
        got = out_tdata;
        if (rgb_expected_q.size() == 0) begin
          $display("%0t: unexpected pixel, expected none, got %h", $time, got);
          errors++;
        end else begin
          want = rgb_expected_q.pop_front();
          if (got.red !== want.red) begin
            $display("%0t: red expected %0d got %0d", $time, want.red, got.red);
            errors++;
          end
          if (got.green !== want.green) begin
            $display("%0t: green expected %0d got %0d", $time, want.green, got.green);
            errors++;
          end
          if (got.blue !== want.blue) begin
            $display("%0t: blue expected %0d got %0d", $time, want.blue, got.blue);
            errors++;
          end
        end
      end
      waiting = rgb_expected_q.size();
    end
  end

endmodule

// File: dv/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Stream test of the HSV to RGB converter with random idling and back-pressure.
// ----------------------------------------------------------------------------
// A short directed set covers the corners of each field, every hue sector
// and its edges, grey and black pixels, and hues at and above 360 degrees,
// which must saturate into the last sector. Random pixels follow in three
// phases: a slow receiver, then a slow sender, then neither idles. At the
// start of the last phase the receiver holds off for a long stretch while
// requests keep coming, so the pipeline fills and in_tready must drop. The
// checker beside the block predicts every pixel and compares it field by
// field; this module drives requests and out_tready and reports the verdict.
// ----------------------------------------------------------------------------
module tb;
  import h2r_pkg::*;

  localparam int HFB          = 6;
  localparam int DEG          = 1 << HFB;       // one degree of hue
  localparam int HUE_TOP      = (1 << HUE_W) - 1;
  localparam int PHASE_ITEMS  = 633;
  localparam int HOLD_CYCLES  = 64;
  localparam int DRAIN_CYCLES = 20;
  localparam int RUN_LIMIT_NS = 2_400_000;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [31:0] in_tdata;
  logic        out_tvalid;
  logic        out_tready;
  logic [23:0] out_tdata;
  int          mismatch_count;
  int          pending_count;

  // Idle percentages of each side, changed between phases.
  int tx_idle_pct = 7;
  int rx_idle_pct = 88;
  // A long receiver hold-off is asked for by raising hold_reqs.
  int hold_reqs   = 0;
  int holds_done  = 0;

  hsv_to_rgb_converter_core #(
    .HUE_FRAC_BITS(HFB)
  ) u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  hsv_to_rgb_converter_checker #(
    .HUE_FRAC_BITS(HFB)
  ) u_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_tvalid     (in_tvalid),
    .in_tready     (in_tready),
    .in_tdata      (in_tdata),
    .out_tvalid    (out_tvalid),
    .out_tready    (out_tready),
    .out_tdata     (out_tdata),
    .mismatch_count(mismatch_count),
    .pending_count (pending_count)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // The run must never take longer than this, even with the slowest sides.
  initial begin
    #RUN_LIMIT_NS;
    $display("CHECKS FAILED");
    $finish;
  end

  // Offers one pixel request, idling first at the sender's rate, and returns
  // at the falling edge after it was accepted with in_tvalid still high.
  task automatic send_pixel(input int hue, input int sat, input int val);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {1'b0, CH_W'(val), CH_W'(sat), HUE_W'(hue)};
    do @(posedge clk); while (!in_tready);
    @(negedge clk);
  endtask

  // Saturation and brightness lean toward their extremes now and then.
  function automatic int pick_level();
    if ($urandom_range(9) == 0) begin
      return $urandom_range(1) ? 255 : 0;
    end
    return $urandom_range(255);
  endfunction

  function automatic int pick_hue();
    int roll;
    roll = $urandom_range(99);
    if (roll < 85) begin
      return $urandom_range(360 * DEG - 1);
    end else if (roll < 93) begin
      // Right at a sector edge, on either side of it.
      return $urandom_range(1, 5) * 60 * DEG - $urandom_range(0, 1);
    end
    // At or beyond 360 degrees, which must clamp to the last hue code.
    return $urandom_range(360 * DEG, HUE_TOP);
  endfunction

  // Receiver: random ready, or a long hold-off when one is requested.
  initial begin : receiver
    int hold_left;
    hold_left  = 0;
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (holds_done != hold_reqs) begin
        holds_done = hold_reqs;
        hold_left  = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  initial begin : stimulus
    rst_n     = 1'b0;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed pixels: field extremes, each sector, both sides of the 60 and
    // 120 degree edges, grey, black, and hues at and above the 360 degree limit.
    send_pixel(0, 255, 255);
    send_pixel(60 * DEG - 1, 255, 255);
    send_pixel(60 * DEG, 255, 255);
    send_pixel(90 * DEG, 255, 255);
    send_pixel(120 * DEG - 1, 255, 200);
    send_pixel(120 * DEG, 255, 200);
    send_pixel(150 * DEG, 100, 180);
    send_pixel(180 * DEG, 255, 255);
    send_pixel(210 * DEG, 255, 255);
    send_pixel(240 * DEG, 200, 255);
    send_pixel(270 * DEG, 1, 254);
    send_pixel(300 * DEG, 255, 255);
    send_pixel(330 * DEG, 255, 255);
    send_pixel(360 * DEG - 1, 255, 255);
    send_pixel(360 * DEG, 255, 255);
    send_pixel(HUE_TOP, 255, 255);
    send_pixel(HUE_TOP, 0, 0);
    send_pixel(0, 0, 0);
    send_pixel(12345, 0, 255);
    send_pixel(5000, 255, 0);
    send_pixel(30 * DEG, 128, 128);
    send_pixel(16383, 170, 85);
    send_pixel(2730, 85, 170);
    send_pixel(23000, 254, 1);

    for (int phase = 0; phase < 3; phase++) begin
      if (phase == 1) begin
        tx_idle_pct = 88;
        rx_idle_pct = 7;
      end else if (phase == 2) begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        // Stall the receiver while requests keep arriving every cycle.
        hold_reqs++;
      end
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        send_pixel(pick_hue(), pick_level(), pick_level());
      end
    end
    in_tvalid <= 1'b0;

    // Let every expected pixel come out, then watch a little longer for
    // anything extra.
    wait (pending_count == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && pending_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
